>>> rtl/core/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

	// replacement unit after reset
	localparam logic [15:0] REPL_RESET = 16'h003F;

	// surrogate bases and supplementary offset
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [15:0] SURR_LAST    = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [20:0] CODE_MAX     = 21'h10FFFF;

	// sequence lengths
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// open sequence state
	typedef struct packed {
		logic [23:0] gathered;
		logic [1:0]  need;
		logic [2:0]  len;
	} seq_state_t;

	// one result unit
	typedef struct packed {
		logic [15:0] code;
		logic        last;
		logic        eos;
	} unit_t;

	// outcome of decoding one byte
	typedef struct packed {
		logic [1:0] count;
		unit_t      u0;
		unit_t      u1;
		seq_state_t next;
	} dec_res_t;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

>>> rtl/core/u8u16_if.sv
`timescale 1ns / 1ps

// byte request channel
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;

	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

// code unit request channel
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_item;
	logic        end_of_string;

	modport source (output valid, output code_unit, output last_of_item,
		output end_of_string, input ready);
	modport sink   (input valid, input code_unit, input last_of_item,
		input end_of_string, output ready);
endinterface

>>> rtl/core/u8u16_dec.sv
`timescale 1ns / 1ps

// Decode step for one byte against the open sequence state.
module u8u16_dec (
	input  u8u16_pkg::seq_state_t st,
	input  logic [7:0]            in_byte,
	input  logic                  final_byte,
	input  logic [15:0]           repl,
	output u8u16_pkg::dec_res_t   res
);

	logic [7:0]  b0, b1, b2;
	logic [15:0] v3;
	logic [20:0] v4;
	logic [20:0] v4_off;
	logic [15:0] hi_unit, lo_unit;
	logic [1:0]  fin_count;
	logic [15:0] fin_u0;

	// field extraction for the completing byte
	assign b0 = (st.len == u8u16_pkg::LEN_FOUR) ? st.gathered[23:16] :
		(st.len == u8u16_pkg::LEN_THREE) ? st.gathered[15:8] : st.gathered[7:0];
	assign b1 = (st.len == u8u16_pkg::LEN_FOUR) ? st.gathered[15:8] : st.gathered[7:0];
	assign b2 = st.gathered[7:0];
	assign v3 = {b0[3:0], b1[5:0], in_byte[5:0]};
	assign v4 = {b0[2:0], b1[5:0], b2[5:0], in_byte[5:0]};
	assign v4_off = v4 - u8u16_pkg::SUPP_BASE;
	assign hi_unit = u8u16_pkg::HI_SURR_BASE + {6'd0, v4_off[19:10]};
	assign lo_unit = u8u16_pkg::LO_SURR_BASE + {6'd0, v4[9:0]};

	// completion of an open sequence
	always_comb begin
		fin_count = 2'd1;
		fin_u0 = repl;
		case (st.len)
			u8u16_pkg::LEN_TWO: begin
				if (b0[4:1] != 4'd0 && u8u16_pkg::is_cont(in_byte))
					fin_u0 = {5'd0, b0[4:0], in_byte[5:0]};
			end
			u8u16_pkg::LEN_THREE: begin
				if (!(b0 == 8'hE0 && b1[7:5] == 3'b100) && u8u16_pkg::is_cont(b1)
						&& u8u16_pkg::is_cont(in_byte)
						&& !(v3 >= u8u16_pkg::HI_SURR_BASE && v3 <= u8u16_pkg::SURR_LAST))
					fin_u0 = v3;
			end
			u8u16_pkg::LEN_FOUR: begin
				if (u8u16_pkg::is_cont(b1) && u8u16_pkg::is_cont(b2)
						&& u8u16_pkg::is_cont(in_byte)
						&& v4 >= u8u16_pkg::SUPP_BASE && v4 <= u8u16_pkg::CODE_MAX) begin
					fin_u0 = hi_unit;
					fin_count = 2'd2;
				end
			end
			default: ;
		endcase
	end

	// state update and unit selection
	always_comb begin
		res = '0;
		res.next = st;
		if (st.need == 2'd0) begin
			res.count = 2'd1;
			res.u0.code = repl;
			if (in_byte[7] == 1'b0) begin
				res.u0.code = {8'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110
					|| in_byte[7:3] == 5'b11110) begin
				res.next.gathered = {16'd0, in_byte};
				if (in_byte[5] == 1'b0)
					res.next.len = u8u16_pkg::LEN_TWO;
				else if (in_byte[4] == 1'b0)
					res.next.len = u8u16_pkg::LEN_THREE;
				else
					res.next.len = u8u16_pkg::LEN_FOUR;
				res.next.need = res.next.len[1:0] - 2'd1;
				if (final_byte)
					res.next = '0;
				else
					res.count = 2'd0;
			end
		end else if (st.need != 2'd1) begin
			res.next.gathered = {st.gathered[15:0], in_byte};
			res.next.need = st.need - 2'd1;
			if (final_byte) begin
				res.next = '0;
				res.count = 2'd1;
				res.u0.code = repl;
			end
		end else begin
			res.next = '0;
			res.count = fin_count;
			res.u0.code = fin_u0;
			res.u1.code = lo_unit;
		end

		// flags on the last unit of this byte
		if (res.count == 2'd2) begin
			res.u1.last = 1'b1;
			res.u1.eos = final_byte;
		end else begin
			res.u0.last = 1'b1;
			res.u0.eos = final_byte;
		end
	end

endmodule

>>> rtl/core/utf8_to_utf16_stream_decoder_unit.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-16 stream decoder. One byte is taken per cycle into an input
// register and decoded there against the open sequence state; the resulting
// zero, one or two code units go into a two-entry output buffer. A byte that
// completes a supplementary character yields a surrogate pair, which leaves
// the buffer one unit after the other; the three bytes before it yield
// nothing, so the buffer has drained by then. With the sink always ready a
// stream therefore flows without a stall, and the input stalls only while
// the sink holds units back and the buffer has no room for the units of the
// waiting byte. A byte passes the input register, then the output buffer. The
// replacement unit register may be written only while the decoder is idle.
module utf8_to_utf16_stream_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	u8u16_byte_if.sink          bytes,
	u8u16_unit_if.source        units
);

	logic [15:0]           repl_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  fin_s1;
	u8u16_pkg::seq_state_t state_q;
	u8u16_pkg::dec_res_t   dec;
	u8u16_pkg::unit_t      buf_q [2];
	logic [1:0]            cnt_q;
	logic                  pop;
	logic [1:0]            cnt_pop;
	logic                  proc;
	u8u16_pkg::unit_t      buf_d [2];
	logic [1:0]            cnt_d;

	// replacement register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= u8u16_pkg::REPL_RESET;
		end else if (cfg_we) begin
			repl_q <= cfg_wdata;
		end
	end

	u8u16_dec u_dec (
		.st        (state_q),
		.in_byte   (byte_s1),
		.final_byte(fin_s1),
		.repl      (repl_q),
		.res       (dec)
	);

	// buffer room check
	assign pop = units.valid && units.ready;
	assign cnt_pop = cnt_q - {1'b0, pop};
	assign proc = valid_s1 && ({1'b0, cnt_pop} + {1'b0, dec.count} <= 3'd2);
	assign bytes.ready = !valid_s1 || proc;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.in_byte;
			fin_s1  <= bytes.final_byte;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc) begin
			state_q <= dec.next;
		end
	end

	// output buffer next value
	always_comb begin
		buf_d[0] = buf_q[0];
		buf_d[1] = buf_q[1];
		if (pop)
			buf_d[0] = buf_q[1];
		cnt_d = cnt_pop;
		if (proc) begin
			if (dec.count != 2'd0) begin
				if (cnt_pop == 2'd0)
					buf_d[0] = dec.u0;
				else
					buf_d[1] = dec.u0;
			end
			if (dec.count == 2'd2)
				buf_d[1] = dec.u1;
			cnt_d = cnt_pop + dec.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		buf_q[0] <= buf_d[0];
		buf_q[1] <= buf_d[1];
	end

	assign units.valid         = cnt_q != 2'd0;
	assign units.code_unit     = buf_q[0].code;
	assign units.last_of_item  = buf_q[0].last;
	assign units.end_of_string = buf_q[0].eos;

endmodule

>>> bench/tb_utf8_to_utf16_stream_decoder_unit.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16_stream_decoder_unit;

	localparam int CLK_PERIOD    = 12;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES   = 275;
	localparam int GAP_PERCENT   = 13;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_stream_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bytes     (byte_ch),
		.units     (unit_ch)
	);

	// byte requests waiting for the driver, and the string under construction
	byte_req_t   pending_bytes [$];
	logic [7:0]  draft_bytes [$];
	byte_req_t   next_req;

	// expected code units, oldest first
	u8u16_pkg::unit_t expected_units [$];
	u8u16_pkg::unit_t want;

	// decoder state as predicted
	logic [15:0] repl_unit;
	logic [23:0] open_bytes;
	logic [1:0]  bytes_missing;
	logic [2:0]  open_len;

	bit          no_gaps = 1'b0;
	int          errors = 0;
	int          bytes_queued = 0;
	int          bytes_accepted = 0;
	int          units_checked = 0;
	int          strings_sent = 0;
	int          settings_used = 1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic void close_sequence();
		open_bytes    = '0;
		bytes_missing = '0;
		open_len      = u8u16_pkg::LEN_NONE;
	endfunction

	// judge a complete sequence whose last byte is b; returns the unit count
	function automatic int finish_sequence(input logic [7:0] b, output logic [15:0] hi,
			output logic [15:0] lo);
		logic [7:0]  b0, b1, b2;
		logic [15:0] bmp;
		logic [20:0] cp;
		logic [19:0] offs;
		hi = repl_unit;
		lo = '0;
		case (open_len)
			u8u16_pkg::LEN_TWO: begin
				b0 = open_bytes[7:0];
				if (b0[4:1] != 4'd0 && b[7:6] == 2'b10)
					hi = {5'd0, b0[4:0], b[5:0]};
				return 1;
			end
			u8u16_pkg::LEN_THREE: begin
				b0  = open_bytes[15:8];
				b1  = open_bytes[7:0];
				bmp = {b0[3:0], b1[5:0], b[5:0]};
				// E0 with 80-9F is overlong; D800-DFFF is a surrogate value
				if (!(b0 == 8'hE0 && b1[7:5] == 3'b100) && b1[7:6] == 2'b10 &&
						b[7:6] == 2'b10 && !(bmp >= 16'hD800 && bmp <= 16'hDFFF))
					hi = bmp;
				return 1;
			end
			u8u16_pkg::LEN_FOUR: begin
				b0 = open_bytes[23:16];
				b1 = open_bytes[15:8];
				b2 = open_bytes[7:0];
				cp = {b0[2:0], b1[5:0], b2[5:0], b[5:0]};
				if (b1[7:6] != 2'b10 || b2[7:6] != 2'b10 || b[7:6] != 2'b10 ||
						cp <= 21'h00FFFF || cp > 21'h10FFFF)
					return 1;
				offs = 20'(cp - 21'h010000);
				hi   = 16'hD800 + {6'd0, offs[19:10]};
				lo   = 16'hDC00 + {6'd0, offs[9:0]};
				return 2;
			end
			default: return 1;
		endcase
	endfunction

	// advance the predicted state by one byte and queue the units it yields
	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		logic [15:0]      codes [2];
		logic [2:0]       lead_len;
		u8u16_pkg::unit_t u;
		int               n_units;
		int               k;
		n_units  = 0;
		lead_len = u8u16_pkg::LEN_NONE;
		codes[0] = '0;
		codes[1] = '0;
		if (bytes_missing == 2'd0) begin
			if (b[7] == 1'b0) begin
				codes[0] = {8'h00, b};
				n_units  = 1;
			end else if (b[7:5] == 3'b110) begin
				lead_len = u8u16_pkg::LEN_TWO;
			end else if (b[7:4] == 4'b1110) begin
				lead_len = u8u16_pkg::LEN_THREE;
			end else if (b[7:3] == 5'b11110) begin
				lead_len = u8u16_pkg::LEN_FOUR;
			end else begin
				// stray continuation or F8-FF
				codes[0] = repl_unit;
				n_units  = 1;
			end
			if (lead_len != u8u16_pkg::LEN_NONE) begin
				if (fin) begin
					// string ends right at a lead byte
					codes[0] = repl_unit;
					n_units  = 1;
				end else begin
					open_bytes    = {16'h0000, b};
					open_len      = lead_len;
					bytes_missing = 2'(lead_len - 3'd1);
				end
			end
		end else if (bytes_missing > 2'd1) begin
			if (fin) begin
				// cut-off sequence
				close_sequence();
				codes[0] = repl_unit;
				n_units  = 1;
			end else begin
				open_bytes    = {open_bytes[15:0], b};
				bytes_missing = bytes_missing - 2'd1;
			end
		end else begin
			n_units = finish_sequence(b, codes[0], codes[1]);
			close_sequence();
		end
		for (k = 0; k < n_units; k++) begin
			u.code = codes[k];
			u.last = (k == n_units - 1);
			u.eos  = (k == n_units - 1) && fin;
			expected_units.push_back(u);
		end
	endfunction

	// ---------------------------------------------------------------
	// Driver: byte requests from the pending queue
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid      <= 1'b0;
			byte_ch.in_byte    <= '0;
			byte_ch.final_byte <= 1'b0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (pending_bytes.size() != 0 &&
					(no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
				next_req = pending_bytes.pop_front();
				byte_ch.valid      <= 1'b1;
				byte_ch.in_byte    <= next_req.data;
				byte_ch.final_byte <= next_req.fin;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predict on accepted bytes, check accepted units
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ch.ready <= 1'b0;
			close_sequence();
		end else begin
			unit_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.in_byte, byte_ch.final_byte);
				bytes_accepted++;
			end
			if (unit_ch.valid && unit_ch.ready) begin
				if (expected_units.size() == 0) begin
					$display("%0t: unexpected code unit: expected none, got %h",
						$time, unit_ch.code_unit);
					errors++;
				end else begin
					want = expected_units.pop_front();
					units_checked++;
					if (unit_ch.code_unit !== want.code) begin
						$display("%0t: code_unit mismatch: expected %h, got %h",
							$time, want.code, unit_ch.code_unit);
						errors++;
					end
					if (unit_ch.last_of_item !== want.last) begin
						$display("%0t: last_of_item mismatch: expected %b, got %b",
							$time, want.last, unit_ch.last_of_item);
						errors++;
					end
					if (unit_ch.end_of_string !== want.eos) begin
						$display("%0t: end_of_string mismatch: expected %b, got %b",
							$time, want.eos, unit_ch.end_of_string);
						errors++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic push_byte(input logic [7:0] data, input logic fin);
		byte_req_t req;
		req.data = data;
		req.fin  = fin;
		pending_bytes.push_back(req);
		bytes_queued++;
	endtask

	// encode cp at a forced length; high bits that do not fit are dropped
	task automatic add_code_point(input logic [20:0] cp, input int nbytes);
		case (nbytes)
			1: draft_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				draft_bytes.push_back({3'b110, cp[10:6]});
				draft_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				draft_bytes.push_back({4'b1110, cp[15:12]});
				draft_bytes.push_back({2'b10, cp[11:6]});
				draft_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				draft_bytes.push_back({5'b11110, cp[20:18]});
				draft_bytes.push_back({2'b10, cp[17:12]});
				draft_bytes.push_back({2'b10, cp[11:6]});
				draft_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic add_random_sequence();
		int          pick;
		int          nbytes;
		int          start;
		logic [20:0] cp;
		pick = $urandom_range(99);
		if (pick < 70) begin
			// shortest encoding of a code point; the 3-byte range includes surrogates
			nbytes = (pick < 25) ? 1 : (pick < 40) ? 2 : (pick < 55) ? 3 : 4;
			case (nbytes)
				1: cp = 21'($urandom_range(21'h00007F));
				2: cp = 21'($urandom_range(21'h0007FF, 21'h000080));
				3: cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
				default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
			endcase
			add_code_point(cp, nbytes);
		end else if (pick < 78) begin
			// any value at two to four bytes: overlong, surrogate, beyond range
			nbytes = $urandom_range(4, 2);
			cp     = 21'($urandom);
			add_code_point(cp, nbytes);
		end else if (pick < 90) begin
			// one continuation replaced by an arbitrary byte
			nbytes = $urandom_range(4, 2);
			start  = draft_bytes.size();
			cp     = 21'($urandom_range(21'h10FFFF, 21'h000080));
			add_code_point(cp, nbytes);
			draft_bytes[start + $urandom_range(nbytes - 1, 1)] = 8'($urandom);
		end else begin
			draft_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic add_random_string();
		int count;
		int tail_len;
		int i;
		count = $urandom_range(8, 1);
		repeat (count) add_random_sequence();
		// sometimes end the string inside an open sequence
		if ($urandom_range(99) < 12) begin
			tail_len = $urandom_range(4, 2);
			case (tail_len)
				2: draft_bytes.push_back({3'b110, 5'($urandom)});
				3: draft_bytes.push_back({4'b1110, 4'($urandom)});
				default: draft_bytes.push_back({5'b11110, 3'($urandom)});
			endcase
			repeat ($urandom_range(tail_len - 2, 0)) draft_bytes.push_back(8'($urandom));
		end
		for (i = 0; i < draft_bytes.size(); i++)
			push_byte(draft_bytes[i], i == draft_bytes.size() - 1);
		draft_bytes.delete();
		strings_sent++;
	endtask

	// wait until every byte is taken and every unit has come back
	task automatic drain();
		while (bytes_accepted != bytes_queued || expected_units.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_replacement(input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		repl_unit = value;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic random_phase(input logic [15:0] value, input bit gapless);
		int goal;
		write_replacement(value);
		no_gaps = gapless;
		goal    = bytes_queued + PHASE_BYTES;
		while (bytes_queued < goal)
			add_random_string();
		drain();
		no_gaps = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		// ASCII NUL, stray byte, C1 overlong, 2-byte max, E0 overlong,
		// surrogate value, 4-byte at or below FFFF, 4-byte max, beyond range,
		// ASCII absorbed as continuation, string cut off mid-sequence
		logic [7:0] directed_bytes [28];
		int i;

		directed_bytes = '{
			8'h00, 8'hFF, 8'hC1, 8'hBF, 8'hDF, 8'hBF,
			8'hE0, 8'h9F, 8'hBF, 8'hED, 8'hA0, 8'h80,
			8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
			8'hF4, 8'h90, 8'h80, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h82};
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		repl_unit          = u8u16_pkg::REPL_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed string under the reset replacement unit
		for (i = 0; i < 28; i++)
			push_byte(directed_bytes[i], i == 27);
		strings_sent++;
		drain();

		random_phase(16'h0000, 1'b0);
		random_phase(16'hFFFF, 1'b1);
		random_phase(16'($urandom), 1'b0);
		random_phase(16'hFFFD, 1'b0);

		$display("Decoded %0d bytes in %0d strings, %0d code units checked,",
			bytes_accepted, strings_sent, units_checked);
		$display("under %0d replacement unit settings with and without stalls.",
			settings_used);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
